FILE: hdl/cc20_pkg.sv
// Shared types, constants and quarter-round arithmetic for the ChaCha20 block core.
package cc20_pkg;

    // One 32-bit state word and a full 16-word block.
    typedef logic [31:0] word_t;
    typedef word_t [15:0] block_t;

    // Key and nonce words as held by the configuration registers.
    typedef struct packed {
        word_t [7:0] key;
        word_t [2:0] nonce;
    } cfg_t;

    // Four words touched by one quarter round.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } qr_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_0_1   = 3'd0;
    localparam logic [2:0] REG_KEY_2_3   = 3'd1;
    localparam logic [2:0] REG_KEY_4_5   = 3'd2;
    localparam logic [2:0] REG_KEY_6_7   = 3'd3;
    localparam logic [2:0] REG_NONCE_0_1 = 3'd4;
    localparam logic [2:0] REG_NONCE_2   = 3'd5;

    // The four sigma words ("expand 32-byte k").
    localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    // Depth of the counter queue between front and engine.
    localparam int QDEPTH = 2;

    // Index of the final word of a block.
    localparam logic [3:0] LAST_INDEX = 4'd15;

    // Half a quarter round: two add, xor, rotate steps.
    // The first half rotates by 16 and 12, the second half by 8 and 7.
    function automatic qr_t qr_half(input word_t a, input word_t b, input word_t c,
                                    input word_t d, input logic second);
        qr_t   res;
        word_t x;
        word_t y;
        res.a = a + b;
        x     = d ^ res.a;
        res.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        res.c = c + res.d;
        y     = b ^ res.c;
        res.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
        return res;
    endfunction

endpackage

FILE: hdl/cc20_front.sv
// Input side: takes block counters off the stream and queues them for the round engine.
module cc20_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cc20_pkg::word_t     s_tdata,     // [31:0] block_counter
    output logic                cnt_valid,
    input  logic                cnt_ready,
    output cc20_pkg::word_t     cnt_data
);
    import cc20_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    word_t              mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    // Queue status drives both handshakes.
    assign s_tready  = (count_reg != CNT_W'(QDEPTH));
    assign cnt_valid = (count_reg != '0);
    assign cnt_data  = mem_reg[rd_ptr_reg];
    assign push      = s_tvalid & s_tready;
    assign pop       = cnt_valid & cnt_ready;

    // Fill level follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_tdata;
        end
    end

    // The fill level never passes the queue depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QDEPTH))
        else $error("counter queue overfilled");

endmodule

FILE: hdl/cc20_engine.sv
// Round engine: builds the initial state, runs the double rounds and adds the input state.
module cc20_engine #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cc20_pkg::cfg_t      cfg,
    input  logic                cnt_valid,
    output logic                cnt_ready,
    input  cc20_pkg::word_t     cnt_data,
    output logic                blk_valid,
    input  logic                blk_ready,
    output cc20_pkg::block_t    blk_data
);
    import cc20_pkg::*;

    localparam int STEPS  = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(STEPS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [STEP_W-1:0]  step_reg;
    block_t             work_reg;
    block_t             init_reg;
    block_t             start_state;
    block_t             round_next;
    word_t              col_next  [16];
    word_t              diag_next [16];
    logic               second_half;
    logic               diag_round;
    logic               last_step;
    logic               start;

    // Step bit 0 picks the half of a quarter round, bit 1 column or diagonal.
    assign second_half = step_reg[0];
    assign diag_round  = step_reg[1];
    assign last_step   = (step_reg == STEP_W'(STEPS - 1));

    assign cnt_ready = (state_reg == ST_IDLE);
    assign start     = cnt_valid & cnt_ready;
    assign blk_valid = (state_reg == ST_DONE);

    // Initial state from sigma, key, counter and nonce.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            start_state[k] = SIGMA[k];
        end
        for (int k = 0; k < 8; k++) begin
            start_state[4 + k] = cfg.key[k];
        end
        start_state[12] = cnt_data;
        for (int k = 0; k < 3; k++) begin
            start_state[13 + k] = cfg.nonce[k];
        end
    end

    // Four quarter rounds in parallel, half of each per cycle.
    always_comb begin
        qr_t cq;
        qr_t dq;
        for (int i = 0; i < 4; i++) begin
            cq = qr_half(work_reg[i], work_reg[4 + i], work_reg[8 + i], work_reg[12 + i],
                         second_half);
            col_next[i]      = cq.a;
            col_next[4 + i]  = cq.b;
            col_next[8 + i]  = cq.c;
            col_next[12 + i] = cq.d;
            dq = qr_half(work_reg[i], work_reg[4 + ((i + 1) & 3)],
                         work_reg[8 + ((i + 2) & 3)], work_reg[12 + ((i + 3) & 3)],
                         second_half);
            diag_next[i]                  = dq.a;
            diag_next[4 + ((i + 1) & 3)]  = dq.b;
            diag_next[8 + ((i + 2) & 3)]  = dq.c;
            diag_next[12 + ((i + 3) & 3)] = dq.d;
        end
        for (int k = 0; k < 16; k++) begin
            round_next[k] = diag_round ? diag_next[k] : col_next[k];
        end
    end

    // Feed-forward addition of the initial state.
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            blk_data[k] = work_reg[k] + init_reg[k];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (blk_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (start) begin
                step_reg <= '0;
            end else if (state_reg == ST_ROUND) begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // State words are payload and need no reset.
    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= start_state;
            init_reg <= start_state;
        end else if (state_reg == ST_ROUND) begin
            work_reg <= round_next;
        end
    end

    // The last round step always hands over to the done state.
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && last_step) |=> (state_reg == ST_DONE))
        else $error("round sequence did not finish");

endmodule

FILE: hdl/cc20_emit.sv
// Output side: holds one finished block and sends its sixteen words in order.
module cc20_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                blk_valid,
    output logic                blk_ready,
    input  cc20_pkg::block_t    blk_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,     // [31:0] keystream_word, [35:32] word_index
    output logic                m_tlast      // last_word
);
    import cc20_pkg::*;

    block_t         buf_reg;
    logic           buf_valid_reg;
    logic [3:0]     idx_reg;
    logic           load;
    logic           xfer;

    assign blk_ready = !buf_valid_reg;
    assign load      = blk_valid & blk_ready;
    assign xfer      = m_tvalid & m_tready;

    // Current word of the held block.
    assign m_tvalid = buf_valid_reg;
    assign m_tdata  = {4'b0000, idx_reg, buf_reg[idx_reg]};
    assign m_tlast  = (idx_reg == LAST_INDEX);

    // Buffer state and word index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (load) begin
                buf_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (xfer) begin
                idx_reg <= idx_reg + 4'd1;
                if (idx_reg == LAST_INDEX) begin
                    buf_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= blk_data;
        end
    end

    // A transfer of the last word frees the buffer.
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && m_tlast) |=> !buf_valid_reg)
        else $error("buffer still held after last word");

    // A new block always starts at word zero.
    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (buf_valid_reg && idx_reg == '0))
        else $error("block load did not restart the word index");

endmodule

FILE: hdl/chacha20_block_function_core.sv
// Top level of the ChaCha20 block core: configuration registers and the three stages.
//
//  Channel   Direction  Carries
//  s_*       in         block_counter in s_tdata
//  m_*       out        keystream_word, word_index in m_tdata; last_word in m_tlast
//  cfg_*     in         register index and 64-bit write data
//
// In the round engine each block is loaded, then all four quarter rounds advance half a
// quarter round per cycle, and the finished block is handed over from the done state.
// Sixteen output words of one block go out while the next block is computed.
// Reset is synchronous and active low; it clears all control state and the key and nonce.
// A stalled output holds the engine only once its finished block cannot be handed over.
module chacha20_block_function_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,     // [31:0] block_counter
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,     // [31:0] keystream_word, [35:32] word_index
    output logic                m_tlast,     // last_word
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_wdata
);
    import cc20_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic       cnt_valid;
    logic       cnt_ready;
    word_t      cnt_data;
    logic       blk_valid;
    logic       blk_ready;
    block_t     blk_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_KEY_0_1: begin
                    cfg_reg.key[0] <= cfg_wdata[31:0];
                    cfg_reg.key[1] <= cfg_wdata[63:32];
                end
                REG_KEY_2_3: begin
                    cfg_reg.key[2] <= cfg_wdata[31:0];
                    cfg_reg.key[3] <= cfg_wdata[63:32];
                end
                REG_KEY_4_5: begin
                    cfg_reg.key[4] <= cfg_wdata[31:0];
                    cfg_reg.key[5] <= cfg_wdata[63:32];
                end
                REG_KEY_6_7: begin
                    cfg_reg.key[6] <= cfg_wdata[31:0];
                    cfg_reg.key[7] <= cfg_wdata[63:32];
                end
                REG_NONCE_0_1: begin
                    cfg_reg.nonce[0] <= cfg_wdata[31:0];
                    cfg_reg.nonce[1] <= cfg_wdata[63:32];
                end
                REG_NONCE_2: begin
                    cfg_reg.nonce[2] <= cfg_wdata[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    cc20_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cnt_valid (cnt_valid),
        .cnt_ready (cnt_ready),
        .cnt_data  (cnt_data)
    );

    cc20_engine #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cnt_valid (cnt_valid),
        .cnt_ready (cnt_ready),
        .cnt_data  (cnt_data),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data)
    );

    cc20_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
